@@ src/trfr_pkg.sv @@
`timescale 1ns / 1ps

package trfr_pkg;

  // Field widths of the transfer payloads
  localparam int TICK_W      = 31;
  localparam int WRAP_W      = 31;
  localparam int NUMER_W     = 31;
  localparam int NS_DENOM_W  = 30;
  localparam int US_DENOM_W  = 20;
  localparam int MS_DENOM_W  = 10;
  localparam int LIMIT_W     = 64;

  // Widest denominator, used for the per-unit store
  localparam int DENOM_W     = NS_DENOM_W;

  // Default number of rate bits taken from the input
  localparam int RATE_BITS_DEF = 31;

  // Unit slots
  typedef logic [1:0] unit_t;
  localparam unit_t UNIT_NS   = 2'd0;
  localparam unit_t UNIT_US   = 2'd1;
  localparam unit_t UNIT_MS   = 2'd2;
  localparam unit_t UNIT_LAST = UNIT_MS;
  localparam int    UNITS     = 3;

  // Divider operations run by the datapath
  typedef enum logic [1:0] {
    OP_GCD,
    OP_NUMER,
    OP_DENOM,
    OP_LIMIT
  } op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GCD_INIT,
    ST_GCD_TEST,
    ST_RUN,
    ST_WAIT,
    ST_PUBLISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic  load;
    logic  zero_fill;
    logic  gcd_init;
    logic  start;
    logic  publish;
    op_t   op;
    unit_t unit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic rate_zero;
    logic y_zero;
    logic div_done;
  } status_t;

  // Result payload
  typedef struct packed {
    logic [WRAP_W-1:0]     wrap_mask;
    logic [NUMER_W-1:0]    ns_numer;
    logic [NS_DENOM_W-1:0] ns_denom;
    logic [LIMIT_W-1:0]    ns_limit;
    logic [NUMER_W-1:0]    us_numer;
    logic [US_DENOM_W-1:0] us_denom;
    logic [LIMIT_W-1:0]    us_limit;
    logic [NUMER_W-1:0]    ms_numer;
    logic [MS_DENOM_W-1:0] ms_denom;
    logic [LIMIT_W-1:0]    ms_limit;
  } rsp_t;

  // Units per second for each slot
  function automatic logic [DENOM_W-1:0] per_sec(input unit_t unit);
    logic [DENOM_W-1:0] v;
    unique case (unit)
      UNIT_NS: v = DENOM_W'(1000000000);
      UNIT_US: v = DENOM_W'(1000000);
      UNIT_MS: v = DENOM_W'(1000);
      default: v = DENOM_W'(1000);
    endcase
    return v;
  endfunction

endpackage

@@ src/trfr_in_if.sv @@
`timescale 1ns / 1ps

interface trfr_in_if;
  import trfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [TICK_W-1:0] tick_rate;

  modport source (output valid, output tick_rate, input ready);
  modport sink   (input valid, input tick_rate, output ready);
endinterface

@@ src/trfr_out_if.sv @@
`timescale 1ns / 1ps

interface trfr_out_if;
  import trfr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [WRAP_W-1:0]     wrap_mask;
  logic [NUMER_W-1:0]    ns_numer;
  logic [NS_DENOM_W-1:0] ns_denom;
  logic [LIMIT_W-1:0]    ns_limit;
  logic [NUMER_W-1:0]    us_numer;
  logic [US_DENOM_W-1:0] us_denom;
  logic [LIMIT_W-1:0]    us_limit;
  logic [NUMER_W-1:0]    ms_numer;
  logic [MS_DENOM_W-1:0] ms_denom;
  logic [LIMIT_W-1:0]    ms_limit;

  modport source (
    output valid, output wrap_mask,
    output ns_numer, output ns_denom, output ns_limit,
    output us_numer, output us_denom, output us_limit,
    output ms_numer, output ms_denom, output ms_limit,
    input ready
  );
  modport sink (
    input valid, input wrap_mask,
    input ns_numer, input ns_denom, input ns_limit,
    input us_numer, input us_denom, input us_limit,
    input ms_numer, input ms_denom, input ms_limit,
    output ready
  );
endinterface

@@ src/trfr_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle. Short mode runs DW steps on
// a dividend below 2^DW; long mode runs the full 64-bit dividend.
module trfr_div #(
  parameter int DW = 31
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         long_mode,
  input  logic [trfr_pkg::LIMIT_W-1:0] dividend,
  input  logic [DW-1:0]                divisor,
  output logic                         done,
  output logic [trfr_pkg::LIMIT_W-1:0] quot,
  output logic [DW-1:0]                rem
);
  import trfr_pkg::*;

  localparam int QW    = LIMIT_W;
  localparam int SHIFT = QW - DW;
  localparam int CNT_W = $clog2(QW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [QW-1:0]    q;
  logic [DW-1:0]    r;
  logic [DW-1:0]    d;

  logic [DW:0] r2;
  logic [DW:0] diff;
  logic        ge;

  // Trial subtract of the shifted partial remainder
  always_comb begin
    r2   = {r, q[QW-1]};
    diff = r2 - {1'b0, d};
    ge   = (r2 >= {1'b0, d});
  end

  // Load operands, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= long_mode ? CNT_W'(QW) : CNT_W'(DW);
        q    <= long_mode ? dividend : (dividend << SHIFT);
        r    <= '0;
        d    <= divisor;
      end else if (busy) begin
        q   <= {q[QW-2:0], ge};
        r   <= ge ? diff[DW-1:0] : r2[DW-1:0];
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rem  = r;

endmodule

@@ src/trfr_dp.sv @@
`timescale 1ns / 1ps

module trfr_dp #(
  parameter int RATE_BITS = trfr_pkg::RATE_BITS_DEF
) (
  input  logic                        clk,
  input  logic [trfr_pkg::TICK_W-1:0] tick_rate,
  input  trfr_pkg::cmd_t              cmd,
  output trfr_pkg::status_t           status,
  output trfr_pkg::rsp_t              payload
);
  import trfr_pkg::*;

  // GCD operands hold the rate or the largest units-per-second constant
  localparam int DW = (RATE_BITS > DENOM_W) ? RATE_BITS : DENOM_W;

  logic [RATE_BITS-1:0] rate;
  logic [RATE_BITS-1:0] mask;
  logic [DW-1:0]        x;
  logic [DW-1:0]        y;
  logic [RATE_BITS-1:0] numer [UNITS];
  logic [DENOM_W-1:0]   denom [UNITS];
  logic [LIMIT_W-1:0]   limit [UNITS];
  rsp_t                 pl;

  logic [RATE_BITS-1:0] rate_in;
  logic [RATE_BITS-1:0] mask_next;

  logic               div_long;
  logic [LIMIT_W-1:0] div_dividend;
  logic [DW-1:0]      div_divisor;
  logic               div_done;
  logic [LIMIT_W-1:0] div_quot;
  logic [DW-1:0]      div_rem;

  // Smear the bits below the top set bit of rate-1 to get the wrap mask
  always_comb begin
    logic [RATE_BITS-1:0] m;
    rate_in = RATE_BITS'(tick_rate);
    m       = rate_in - RATE_BITS'(1);
    for (int s = 1; s < RATE_BITS; s = s * 2) begin
      m = m | (m >> s);
    end
    mask_next = (rate_in == '0) ? '0 : m;
  end

  // Select divider operands for the running operation
  always_comb begin
    div_long     = 1'b0;
    div_dividend = LIMIT_W'(x);
    div_divisor  = y;
    unique case (cmd.op)
      OP_GCD: begin
        div_dividend = LIMIT_W'(x);
        div_divisor  = y;
      end
      OP_NUMER: begin
        div_dividend = LIMIT_W'(rate);
        div_divisor  = x;
      end
      OP_DENOM: begin
        div_dividend = LIMIT_W'(per_sec(cmd.unit));
        div_divisor  = x;
      end
      OP_LIMIT: begin
        div_long     = 1'b1;
        div_dividend = '1;
        div_divisor  = DW'(numer[cmd.unit]);
      end
    endcase
  end

  trfr_div #(
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .rst       (1'b0),
    .start     (cmd.start),
    .long_mode (div_long),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quot      (div_quot),
    .rem       (div_rem)
  );

  // Working registers: capture, reduce, store per-unit results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rate <= rate_in;
      mask <= mask_next;
    end
    if (cmd.gcd_init) begin
      x <= DW'(rate);
      y <= DW'(per_sec(cmd.unit));
    end
    if (cmd.zero_fill) begin
      for (int i = 0; i < UNITS; i++) begin
        numer[i] <= '0;
        denom[i] <= DENOM_W'(1);
        limit[i] <= '1;
      end
    end
    if (div_done) begin
      unique case (cmd.op)
        OP_GCD: begin
          x <= y;
          y <= div_rem;
        end
        OP_NUMER: numer[cmd.unit] <= RATE_BITS'(div_quot);
        OP_DENOM: denom[cmd.unit] <= DENOM_W'(div_quot);
        OP_LIMIT: limit[cmd.unit] <= div_quot;
      endcase
    end
  end

  // Output register: hold the finished result until transferred
  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      pl.wrap_mask <= WRAP_W'(mask);
      pl.ns_numer  <= NUMER_W'(numer[UNIT_NS]);
      pl.ns_denom  <= NS_DENOM_W'(denom[UNIT_NS]);
      pl.ns_limit  <= limit[UNIT_NS];
      pl.us_numer  <= NUMER_W'(numer[UNIT_US]);
      pl.us_denom  <= US_DENOM_W'(denom[UNIT_US]);
      pl.us_limit  <= limit[UNIT_US];
      pl.ms_numer  <= NUMER_W'(numer[UNIT_MS]);
      pl.ms_denom  <= MS_DENOM_W'(denom[UNIT_MS]);
      pl.ms_limit  <= limit[UNIT_MS];
    end
  end

  assign status.rate_zero = (rate == '0);
  assign status.y_zero    = (y == '0);
  assign status.div_done  = div_done;
  assign payload          = pl;

endmodule

@@ src/trfr_ctrl.sv @@
`timescale 1ns / 1ps

module trfr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  trfr_pkg::status_t status,
  output trfr_pkg::cmd_t    cmd
);
  import trfr_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;
  unit_t  unit, unit_next;
  logic   out_valid_next;
  logic   out_valid_r;

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      op          <= OP_GCD;
      unit        <= UNIT_NS;
      out_valid_r <= 1'b0;
    end else begin
      state       <= state_next;
      op          <= op_next;
      unit        <= unit_next;
      out_valid_r <= out_valid_next;
    end
  end

  // Sequence the reduction of each unit in turn
  always_comb begin
    state_next     = state;
    op_next        = op;
    unit_next      = unit;
    out_valid_next = out_valid_r && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.op         = op;
    cmd.unit       = unit;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.rate_zero) begin
          cmd.zero_fill = 1'b1;
          state_next    = ST_PUBLISH;
        end else begin
          unit_next  = UNIT_NS;
          state_next = ST_GCD_INIT;
        end
      end
      ST_GCD_INIT: begin
        cmd.gcd_init = 1'b1;
        state_next   = ST_GCD_TEST;
      end
      ST_GCD_TEST: begin
        op_next    = status.y_zero ? OP_NUMER : OP_GCD;
        state_next = ST_RUN;
      end
      ST_RUN: begin
        cmd.start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.div_done) begin
          unique case (op)
            OP_GCD:   state_next = ST_GCD_TEST;
            OP_NUMER: begin
              op_next    = OP_DENOM;
              state_next = ST_RUN;
            end
            OP_DENOM: begin
              op_next    = OP_LIMIT;
              state_next = ST_RUN;
            end
            OP_LIMIT: begin
              if (unit == UNIT_LAST) begin
                state_next = ST_PUBLISH;
              end else begin
                unit_next  = unit_t'(unit + unit_t'(1));
                state_next = ST_GCD_INIT;
              end
            end
          endcase
        end
      end
      ST_PUBLISH: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish    = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/tick_rate_fraction_reducer.sv @@
`timescale 1ns / 1ps

// Tick rate fraction reducer: takes one tick rate per transfer and returns the
// wrap mask plus, for nanoseconds, microseconds and milliseconds, the rate
// over units-per-second reduced by a Euclidean GCD and the 64-bit overflow
// limit all-ones / numerator. One item is worked at a time on a single shared
// restoring divider that yields one quotient bit per cycle, with DW = the
// larger of RATE_BITS and 30; each item is captured, checked and published,
// and a zero rate skips the reduction. A new rate is accepted while the
// previous result still waits in the output register.
module tick_rate_fraction_reducer #(
  parameter int RATE_BITS = trfr_pkg::RATE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  trfr_in_if.sink    req,
  trfr_out_if.source rsp
);
  import trfr_pkg::*;

  cmd_t    cmd;
  status_t status;
  rsp_t    payload;

  trfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  trfr_dp #(
    .RATE_BITS (RATE_BITS)
  ) u_dp (
    .clk       (clk),
    .tick_rate (req.tick_rate),
    .cmd       (cmd),
    .status    (status),
    .payload   (payload)
  );

  // Drive the result payload onto the output channel
  assign rsp.wrap_mask = payload.wrap_mask;
  assign rsp.ns_numer  = payload.ns_numer;
  assign rsp.ns_denom  = payload.ns_denom;
  assign rsp.ns_limit  = payload.ns_limit;
  assign rsp.us_numer  = payload.us_numer;
  assign rsp.us_denom  = payload.us_denom;
  assign rsp.us_limit  = payload.us_limit;
  assign rsp.ms_numer  = payload.ms_numer;
  assign rsp.ms_denom  = payload.ms_denom;
  assign rsp.ms_limit  = payload.ms_limit;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import trfr_pkg::*;

  localparam logic [LIMIT_W-1:0] ALL_ONES = {LIMIT_W{1'b1}};
  localparam int STALL_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 118;
  localparam int IDLE_PCT     = 31;
  localparam int DIR_ROWS     = 22;

  // Results that can be read straight off the definition
  localparam rsp_t ZERO_CONSTS = '{
    wrap_mask: '0,
    ns_numer: '0, ns_denom: 30'd1, ns_limit: ALL_ONES,
    us_numer: '0, us_denom: 20'd1, us_limit: ALL_ONES,
    ms_numer: '0, ms_denom: 10'd1, ms_limit: ALL_ONES
  };
  localparam rsp_t ONE_HZ_CONSTS = '{
    wrap_mask: '0,
    ns_numer: 31'd1, ns_denom: 30'd1000000000, ns_limit: ALL_ONES,
    us_numer: 31'd1, us_denom: 20'd1000000, us_limit: ALL_ONES,
    ms_numer: 31'd1, ms_denom: 10'd1000, ms_limit: ALL_ONES
  };
  localparam rsp_t KHZ_CONSTS = '{
    wrap_mask: 31'd1023,
    ns_numer: 31'd1, ns_denom: 30'd1000000, ns_limit: ALL_ONES,
    us_numer: 31'd1, us_denom: 20'd1000, us_limit: ALL_ONES,
    ms_numer: 31'd1, ms_denom: 10'd1, ms_limit: ALL_ONES
  };
  localparam rsp_t GHZ_CONSTS = '{
    wrap_mask: 31'd1073741823,
    ns_numer: 31'd1, ns_denom: 30'd1, ns_limit: ALL_ONES,
    us_numer: 31'd1000, us_denom: 20'd1, us_limit: 64'd18446744073709551,
    ms_numer: 31'd1000000, ms_denom: 10'd1, ms_limit: 64'd18446744073709
  };

  typedef struct {
    logic [TICK_W-1:0] rate;
    bit                typed;
    rsp_t              want;
  } rate_row_t;

  // Directed rates: extremes, zero, unit rates, powers of two, bit patterns
  rate_row_t dir_table [DIR_ROWS] = '{
    '{31'd0,          1'b1, ZERO_CONSTS},
    '{31'd1,          1'b1, ONE_HZ_CONSTS},
    '{31'd1000,       1'b1, KHZ_CONSTS},
    '{31'd1000000000, 1'b1, GHZ_CONSTS},
    '{31'd2,          1'b0, '0},
    '{31'd3,          1'b0, '0},
    '{31'h7FFF_FFFF,  1'b0, '0},
    '{31'h4000_0000,  1'b0, '0},
    '{31'h4000_0001,  1'b0, '0},
    '{31'h3FFF_FFFF,  1'b0, '0},
    '{31'd1000000,    1'b0, '0},
    '{31'd999999999,  1'b0, '0},
    '{31'd1000000007, 1'b0, '0},
    '{31'd32768,      1'b0, '0},
    '{31'd32767,      1'b0, '0},
    '{31'd1024000,    1'b0, '0},
    '{31'd1953125,    1'b0, '0},
    '{31'd500000000,  1'b0, '0},
    '{31'd1280000000, 1'b0, '0},
    '{31'h5555_5555,  1'b0, '0},
    '{31'h2AAA_AAAA,  1'b0, '0},
    '{31'd19200000,   1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  trfr_in_if  req_if ();
  trfr_out_if rsp_if ();

  tick_rate_fraction_reducer i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #1 clk = ~clk;

  rsp_t exp_consts_q [$];
  bit   cur_typed;
  rsp_t cur_want;
  int   rates_taken   = 0;
  int   results_seen  = 0;
  int   zero_rates    = 0;
  int   errors        = 0;
  int   quiet_cycles  = 0;
  int   in_idle_pct   = IDLE_PCT;
  int   out_idle_pct  = IDLE_PCT;

  // Reduce rate / per_sec by Euclid and derive the overflow limit
  function automatic void reduce_rate(input logic [63:0] rate, input logic [63:0] per_sec,
                                      output logic [63:0] numer, output logic [63:0] denom,
                                      output logic [63:0] limit);
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] r;
    if (rate == 0) begin
      numer = 64'd0;
      denom = 64'd1;
      limit = ALL_ONES;
    end else begin
      x = rate;
      y = per_sec;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      numer = rate / x;
      denom = per_sec / x;
      limit = ALL_ONES / numer;
    end
  endfunction

  function automatic rsp_t predict_consts(input logic [TICK_W-1:0] rate);
    rsp_t        c;
    logic [63:0] r;
    logic [63:0] pow2;
    logic [63:0] n;
    logic [63:0] d;
    logic [63:0] l;
    r = 64'(rate);
    pow2 = 64'd1;
    while (pow2 < r) pow2 = pow2 << 1;
    c.wrap_mask = (r == 0) ? '0 : WRAP_W'(pow2 - 64'd1);
    reduce_rate(r, 64'd1000000000, n, d, l);
    c.ns_numer = NUMER_W'(n);
    c.ns_denom = NS_DENOM_W'(d);
    c.ns_limit = l;
    reduce_rate(r, 64'd1000000, n, d, l);
    c.us_numer = NUMER_W'(n);
    c.us_denom = US_DENOM_W'(d);
    c.us_limit = l;
    reduce_rate(r, 64'd1000, n, d, l);
    c.ms_numer = NUMER_W'(n);
    c.ms_denom = MS_DENOM_W'(d);
    c.ms_limit = l;
    return c;
  endfunction

  // Mix of full-range, small, near powers of two, zero and rates sharing factors with 10^k
  function automatic logic [TICK_W-1:0] pick_rate();
    logic [63:0] v;
    int          k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 64'($urandom & 32'h7FFF_FFFF);
      4, 5: v = 64'($urandom_range(1, 4096));
      6: begin
        k = $urandom_range(0, 30);
        v = 64'd1 << k;
        case ($urandom_range(0, 2))
          0: v = v - 64'd1;
          1: v = v + 64'd1;
          default: ;
        endcase
      end
      7, 8: begin
        v = 64'($urandom_range(1, 63)) << $urandom_range(0, 9);
        k = $urandom_range(0, 9);
        repeat (k) v = v * 64'd5;
      end
      default: v = ($urandom_range(0, 2) == 0) ? 64'd0 : 64'd1000 * $urandom_range(1, 2000000);
    endcase
    while (v > 64'h7FFF_FFFF) v = v >> 1;
    return TICK_W'(v);
  endfunction

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Offer one rate and hold it until the transfer is taken
  task automatic send_rate(input logic [TICK_W-1:0] rate, input bit typed, input rsp_t want);
    int taken;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    cur_typed = typed;
    cur_want  = want;
    req_if.valid     <= 1'b1;
    req_if.tick_rate <= rate;
    taken = rates_taken;
    do @(negedge clk); while (rates_taken == taken);
  endtask

  // Record expected constants for each accepted rate
  always @(posedge clk) begin
    if (!rst && req_if.valid && req_if.ready) begin
      exp_consts_q.push_back(cur_typed ? cur_want : predict_consts(req_if.tick_rate));
      if (req_if.tick_rate == 0) zero_rates++;
      rates_taken++;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk) begin : chk_out
    rsp_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (exp_consts_q.size() == 0) begin
        $display("%0t: unexpected result, wrap_mask %0d", $time, rsp_if.wrap_mask);
        errors++;
      end else begin
        want = exp_consts_q.pop_front();
        check_field("wrap_mask", 64'(want.wrap_mask), 64'(rsp_if.wrap_mask));
        check_field("ns_numer",  64'(want.ns_numer),  64'(rsp_if.ns_numer));
        check_field("ns_denom",  64'(want.ns_denom),  64'(rsp_if.ns_denom));
        check_field("ns_limit",  want.ns_limit,       rsp_if.ns_limit);
        check_field("us_numer",  64'(want.us_numer),  64'(rsp_if.us_numer));
        check_field("us_denom",  64'(want.us_denom),  64'(rsp_if.us_denom));
        check_field("us_limit",  want.us_limit,       rsp_if.us_limit);
        check_field("ms_numer",  64'(want.ms_numer),  64'(rsp_if.ms_numer));
        check_field("ms_denom",  64'(want.ms_denom),  64'(rsp_if.ms_denom));
        check_field("ms_limit",  want.ms_limit,       rsp_if.ms_limit);
        results_seen++;
      end
    end
  end

  // Stop the run if no transfer happens for too long
  always @(posedge clk) begin
    if (!rst) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                 $time, quiet_cycles, exp_consts_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin
    rsp_if.ready <= !rst && ($urandom_range(0, 99) >= out_idle_pct);
  end

  initial begin
    int i;
    req_if.valid     = 1'b0;
    req_if.tick_rate = '0;
    rsp_if.ready     = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table
    for (i = 0; i < DIR_ROWS; i++) begin
      send_rate(dir_table[i].rate, dir_table[i].typed, dir_table[i].want);
    end

    // Random rates, with a stretch where neither side idles
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      in_idle_pct  = (i >= 50 && i < 80) ? 0 : IDLE_PCT;
      out_idle_pct = in_idle_pct;
      send_rate(pick_rate(), 1'b0, '0);
    end
    req_if.valid <= 1'b0;
    out_idle_pct = IDLE_PCT;

    // Drain outstanding results, then watch for strays
    while (exp_consts_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d tick rates (%0d directed, %0d with zero rate), checked %0d results",
             rates_taken, DIR_ROWS, zero_rates, results_seen);
    $display("Mismatches and stray results: %0d", errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
